FILE: src/keyboard_report_event_diff_unit_assert.svh
// assertion macros for the keyboard report event diff unit
`ifndef KEYBOARD_REPORT_EVENT_DIFF_UNIT_ASSERT_SVH
`define KEYBOARD_REPORT_EVENT_DIFF_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define KBD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KBD_NEVER(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);
`else
`define KBD_ASSERT(lbl, clk, rst, prop, msg)
`define KBD_NEVER(lbl, clk, rst, prop, msg)
`endif
`endif

FILE: src/kedu_pkg.sv
`default_nettype none
package kedu_pkg;
   localparam int CODE_W      = 16;
   localparam int MOD_W       = 8;
   localparam int MOD_IDX_W   = 3;
   localparam int COUNT_W     = 4;
   localparam int CODE_FIELDS = 8;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEYPAD_MASK = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPS_CODE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOD_BASE    = 2'd2;

   localparam logic [CODE_W-1:0] KEYPAD_MASK_RESET = 16'h4000;
   localparam logic [CODE_W-1:0] CAPS_CODE_RESET   = 16'h8039;
   localparam logic [CODE_W-1:0] MOD_BASE_RESET    = 16'd300;

   typedef logic [CODE_W-1:0] code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_REL,
      ST_PRESS,
      ST_FLUSH
   } seq_state_type;

   typedef struct packed {
      logic     clear;
      logic     load;
      code_type code;
   } slot_cmd_type;

   typedef struct packed {
      logic     occupied;
      logic     in_report;
      logic     probe_hit;
      code_type code;
   } slot_stat_type;
endpackage
`default_nettype wire

FILE: src/kedu_lane.sv
`default_nettype none
module kedu_lane #(
   parameter int KEYS = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire kedu_pkg::slot_cmd_type  cmd,
   input  wire kedu_pkg::code_type      report_key [KEYS],
   input  wire logic [KEYS-1:0]         key_valid,
   input  wire kedu_pkg::code_type      probe_code,
   output kedu_pkg::slot_stat_type      stat
);
   import kedu_pkg::*;

   code_type slot_ff;
   code_type slot_in;
   logic     in_report;

   always_comb begin
      priority if (cmd.clear) begin
         slot_in = '0;
      end else if (cmd.load) begin
         slot_in = cmd.code;
      end else begin
         slot_in = slot_ff;
      end
   end

   // held code against every report key
   always_comb begin
      in_report = 1'b0;
      for (int j = 0; j < KEYS; j++) begin
         if (key_valid[j] && (report_key[j] == slot_ff)) begin
            in_report = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   always_comb begin
      stat.occupied  = (slot_ff != '0);
      stat.in_report = in_report;
      stat.probe_hit = (slot_ff == probe_code);
      stat.code      = slot_ff;
   end
endmodule
`default_nettype wire

FILE: src/kedu_seq.sv
`default_nettype none
`include "keyboard_report_event_diff_unit_assert.svh"
module kedu_seq #(
   parameter int SLOT_COUNT = 8,
   parameter int KEYS       = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [kedu_pkg::MOD_W-1:0]    mods,
   input  wire logic [kedu_pkg::COUNT_W-1:0]  key_count,
   input  wire kedu_pkg::code_type            raw_code [kedu_pkg::CODE_FIELDS],
   input  wire kedu_pkg::code_type            keypad_mask,
   input  wire kedu_pkg::code_type            caps_code,
   input  wire kedu_pkg::code_type            mod_base,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_is_press,
   output kedu_pkg::code_type                 rsp_event_code,
   output logic                               rsp_last_event,
   output kedu_pkg::slot_cmd_type             slot_cmd [SLOT_COUNT],
   input  wire kedu_pkg::slot_stat_type       slot_stat [SLOT_COUNT],
   output kedu_pkg::code_type                 report_key [KEYS],
   output logic [KEYS-1:0]                    key_valid,
   output kedu_pkg::code_type                 probe_code
);
   import kedu_pkg::*;

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int KEY_W  = (KEYS > 1) ? $clog2(KEYS) : 1;

   seq_state_type         state_ff, state_in;
   logic [MOD_IDX_W-1:0]  bit_ff, bit_in;
   logic [SLOT_W-1:0]     slot_idx_ff, slot_idx_in;
   logic [KEY_W-1:0]      key_idx_ff, key_idx_in;
   logic [MOD_W-1:0]      prev_ff, prev_in;
   logic [MOD_W-1:0]      mods_ff, mods_in;
   logic [MOD_W-1:0]      edge_ff, edge_in;
   code_type              key_ff [KEYS];
   code_type              key_in [KEYS];
   logic [KEYS-1:0]       kvalid_ff, kvalid_in;
   logic                  zero_ff, zero_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic                  pend_press_ff, pend_press_in;
   code_type              pend_code_ff, pend_code_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_press_ff, rsp_press_in;
   code_type              rsp_code_ff, rsp_code_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [COUNT_W-1:0]    count_sat;
   code_type              masked [KEYS];
   logic [KEYS-1:0]       cap_valid;
   logic                  cap_zero;
   logic                  can_step;
   logic                  new_ev;
   logic                  new_press;
   code_type              new_code;
   logic                  push;
   logic                  push_last;
   logic                  hit;
   logic                  free_any;
   logic [SLOT_W-1:0]     free_idx;
   slot_stat_type         sel;

   // report capture: clamp count, strip keypad flag, look for the zero code
   always_comb begin
      count_sat = (key_count > COUNT_W'(KEYS)) ? COUNT_W'(KEYS) : key_count;
      cap_zero  = 1'b0;
      for (int j = 0; j < KEYS; j++) begin
         masked[j]    = raw_code[j] & ~keypad_mask;
         cap_valid[j] = (COUNT_W'(j) < count_sat);
         if (cap_valid[j] && (raw_code[j] != caps_code) && (masked[j] == '0)) begin
            cap_zero = 1'b1;
         end
      end
   end

   // merge of the lane results
   always_comb begin
      hit      = 1'b0;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (slot_stat[i].probe_hit) begin
            hit = 1'b1;
         end
         if (!slot_stat[i].occupied && !free_any) begin
            free_any = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   assign sel        = slot_stat[slot_idx_ff];
   assign probe_code = key_ff[key_idx_ff];
   assign can_step   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      bit_in        = bit_ff;
      slot_idx_in   = slot_idx_ff;
      key_idx_in    = key_idx_ff;
      prev_in       = prev_ff;
      mods_in       = mods_ff;
      edge_in       = edge_ff;
      key_in        = key_ff;
      kvalid_in     = kvalid_ff;
      zero_in       = zero_ff;
      pend_valid_in = pend_valid_ff;
      pend_press_in = pend_press_ff;
      pend_code_in  = pend_code_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_press_in  = rsp_press_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_last_in   = rsp_last_ff;
      new_ev        = 1'b0;
      new_press     = 1'b0;
      new_code      = '0;
      push          = 1'b0;
      push_last     = 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_cmd[i] = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (count_sat != '0)) begin
               mods_in    = mods;
               edge_in    = prev_ff ^ mods;
               prev_in    = mods;
               key_in     = masked;
               kvalid_in  = cap_valid;
               zero_in    = cap_zero;
               bit_in     = '0;
               state_in   = ST_MOD;
            end
         end
         ST_MOD: begin
            if (can_step) begin
               new_ev    = edge_ff[bit_ff];
               new_press = mods_ff[bit_ff];
               new_code  = mod_base + CODE_W'(bit_ff);
               if (bit_ff == MOD_IDX_W'(MOD_W - 1)) begin
                  slot_idx_in = '0;
                  state_in    = ST_REL;
               end else begin
                  bit_in = bit_ff + 1'b1;
               end
            end
         end
         ST_REL: begin
            if (can_step) begin
               new_ev   = sel.occupied && (zero_ff || !sel.in_report);
               new_code = sel.code;
               slot_cmd[slot_idx_ff].clear = new_ev;
               if (slot_idx_ff == SLOT_W'(SLOT_COUNT - 1)) begin
                  key_idx_in = '0;
                  state_in   = ST_PRESS;
               end else begin
                  slot_idx_in = slot_idx_ff + 1'b1;
               end
            end
         end
         ST_PRESS: begin
            if (can_step) begin
               new_ev    = kvalid_ff[key_idx_ff] && !hit && free_any;
               new_press = 1'b1;
               new_code  = probe_code;
               slot_cmd[free_idx].load = new_ev;
               slot_cmd[free_idx].code = probe_code;
               if (key_idx_ff == KEY_W'(KEYS - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  key_idx_in = key_idx_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (can_step) begin
               push          = pend_valid_ff;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // one event held back so the final one can carry the last flag
      if (new_ev) begin
         push          = pend_valid_ff;
         push_last     = 1'b0;
         pend_valid_in = 1'b1;
         pend_press_in = new_press;
         pend_code_in  = new_code;
      end

      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_press_in = pend_press_ff;
         rsp_code_in  = pend_code_ff;
         rsp_last_in  = push_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_ff       <= prev_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff        <= bit_in;
      slot_idx_ff   <= slot_idx_in;
      key_idx_ff    <= key_idx_in;
      mods_ff       <= mods_in;
      edge_ff       <= edge_in;
      key_ff        <= key_in;
      kvalid_ff     <= kvalid_in;
      zero_ff       <= zero_in;
      pend_press_ff <= pend_press_in;
      pend_code_ff  <= pend_code_in;
      rsp_press_ff  <= rsp_press_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_press   = rsp_press_ff;
   assign rsp_event_code = rsp_code_ff;
   assign rsp_last_event = rsp_last_ff;
   assign report_key     = key_ff;
   assign key_valid      = kvalid_ff;

   `KBD_NEVER(a_pend_empty_idle, clock, reset,
              (state_ff == ST_IDLE) && pend_valid_ff, "held beat left in idle")
   `KBD_ASSERT(a_last_drains_pend, clock, reset,
               (rsp_valid_ff && rsp_last_ff) |-> !pend_valid_ff, "beat pending behind last")
   `KBD_ASSERT(a_start_mod, clock, reset,
               (req_valid && req_ready && (count_sat != '0)) |=> (state_ff == ST_MOD),
               "report not started")
   `KBD_ASSERT(a_rsp_from_busy, clock, reset,
               $rose(rsp_valid_ff) |-> $past(state_ff != ST_IDLE), "beat issued while idle")
endmodule
`default_nettype wire

FILE: src/keyboard_report_event_diff_unit.sv
`default_nettype none
// keyboard report to key press and release events
// req_ channel: one report per beat (modifier byte, key count, eight key codes).
// rsp_ channel: one event per beat, is_press, event_code, last_event set on the
//   final event of a report; a report that changes nothing gives no beat.
// csr_ channel: register writes, index 0 keypad flag mask, 1 caps lock code,
//   2 modifier event base; always ready, other indexes are ignored.
// sequencing: a sequencer visits one modifier bit, one held slot and one report
//   key per cycle while rsp_ready does not stall it, and takes a new report only
//   once back in idle; a report with key count zero is taken in idle and gives
//   no event. the slot lanes compare all keys in parallel each step.
// the last event of a report waits in the pending register until the flush
//   state moves it into the rsp_ register.
// a new report is taken while the last event still waits on rsp_ready.
// a stalled rsp_ready freezes the sequencer in place; no event is lost.
// reset clears the held slot table, the previous modifier byte and the
//   registers to their default values.
module keyboard_report_event_diff_unit #(
   parameter int SLOT_COUNT  = 8,
   parameter int REPORT_KEYS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [kedu_pkg::MOD_W-1:0]        req_modifier_bits,
   input  wire logic [kedu_pkg::COUNT_W-1:0]      req_key_count,
   input  wire logic [kedu_pkg::CODE_W-1:0]       req_code_a,
   input  wire logic [kedu_pkg::CODE_W-1:0]       req_code_b,
   input  wire logic [kedu_pkg::CODE_W-1:0]       req_code_c,
   input  wire logic [kedu_pkg::CODE_W-1:0]       req_code_d,
   input  wire logic [kedu_pkg::CODE_W-1:0]       req_code_e,
   input  wire logic [kedu_pkg::CODE_W-1:0]       req_code_f,
   input  wire logic [kedu_pkg::CODE_W-1:0]       req_code_g,
   input  wire logic [kedu_pkg::CODE_W-1:0]       req_code_h,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_is_press,
   output logic [kedu_pkg::CODE_W-1:0]            rsp_event_code,
   output logic                                   rsp_last_event,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [kedu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [kedu_pkg::CODE_W-1:0]       csr_wdata
);
   import kedu_pkg::*;

   localparam int KEYS = (REPORT_KEYS < CODE_FIELDS) ? REPORT_KEYS : CODE_FIELDS;

   code_type      keypad_mask_ff, keypad_mask_in;
   code_type      caps_code_ff, caps_code_in;
   code_type      mod_base_ff, mod_base_in;
   code_type      raw_code [CODE_FIELDS];
   code_type      report_key [KEYS];
   logic [KEYS-1:0] key_valid;
   code_type      probe_code;
   slot_cmd_type  slot_cmd [SLOT_COUNT];
   slot_stat_type slot_stat [SLOT_COUNT];

   assign csr_ready = 1'b1;

   always_comb begin
      keypad_mask_in = keypad_mask_ff;
      caps_code_in   = caps_code_ff;
      mod_base_in    = mod_base_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KEYPAD_MASK: keypad_mask_in = csr_wdata;
            CSR_CAPS_CODE:   caps_code_in   = csr_wdata;
            CSR_MOD_BASE:    mod_base_in    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keypad_mask_ff <= KEYPAD_MASK_RESET;
         caps_code_ff   <= CAPS_CODE_RESET;
         mod_base_ff    <= MOD_BASE_RESET;
      end else begin
         keypad_mask_ff <= keypad_mask_in;
         caps_code_ff   <= caps_code_in;
         mod_base_ff    <= mod_base_in;
      end
   end

   assign raw_code[0] = req_code_a;
   assign raw_code[1] = req_code_b;
   assign raw_code[2] = req_code_c;
   assign raw_code[3] = req_code_d;
   assign raw_code[4] = req_code_e;
   assign raw_code[5] = req_code_f;
   assign raw_code[6] = req_code_g;
   assign raw_code[7] = req_code_h;

   kedu_seq #(
      .SLOT_COUNT (SLOT_COUNT),
      .KEYS       (KEYS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .mods           (req_modifier_bits),
      .key_count      (req_key_count),
      .raw_code       (raw_code),
      .keypad_mask    (keypad_mask_ff),
      .caps_code      (caps_code_ff),
      .mod_base       (mod_base_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_press   (rsp_is_press),
      .rsp_event_code (rsp_event_code),
      .rsp_last_event (rsp_last_event),
      .slot_cmd       (slot_cmd),
      .slot_stat      (slot_stat),
      .report_key     (report_key),
      .key_valid      (key_valid),
      .probe_code     (probe_code)
   );

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_lane
      kedu_lane #(
         .KEYS (KEYS)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .cmd        (slot_cmd[i]),
         .report_key (report_key),
         .key_valid  (key_valid),
         .probe_code (probe_code),
         .stat       (slot_stat[i])
      );
   end
endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import kedu_pkg::*;

   localparam int SLOT_COUNT    = 8;
   localparam int REPORT_KEYS   = 8;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 600_000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [MOD_W-1:0]               mods;
      logic [COUNT_W-1:0]             count;
      code_type [CODE_FIELDS-1:0]     codes;
   } key_report_type;

   typedef struct packed {
      logic     is_press;
      code_type code;
      logic     last;
   } key_event_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [MOD_W-1:0]       req_modifier_bits;
   logic [COUNT_W-1:0]     req_key_count;
   code_type               req_code_a;
   code_type               req_code_b;
   code_type               req_code_c;
   code_type               req_code_d;
   code_type               req_code_e;
   code_type               req_code_f;
   code_type               req_code_g;
   code_type               req_code_h;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_is_press;
   code_type               rsp_event_code;
   logic                   rsp_last_event;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   code_type               csr_wdata;

   // predictor state
   code_type         keypad_mask;
   code_type         caps_code;
   code_type         mod_base;
   logic [MOD_W-1:0] last_mods;
   code_type         held_codes [SLOT_COUNT];

   key_event_type  pending_events [$];
   key_event_type  want_event;
   key_report_type last_report;

   int gap_odds;
   int stall_odds;
   int failures;
   int cycle_count;
   int reports_sent;
   int events_checked;
   int reg_writes;

   keyboard_report_event_diff_unit #(
      .SLOT_COUNT  (SLOT_COUNT),
      .REPORT_KEYS (REPORT_KEYS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_modifier_bits (req_modifier_bits),
      .req_key_count     (req_key_count),
      .req_code_a        (req_code_a),
      .req_code_b        (req_code_b),
      .req_code_c        (req_code_c),
      .req_code_d        (req_code_d),
      .req_code_e        (req_code_e),
      .req_code_f        (req_code_f),
      .req_code_g        (req_code_g),
      .req_code_h        (req_code_h),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_is_press      (rsp_is_press),
      .rsp_event_code    (rsp_event_code),
      .rsp_last_event    (rsp_last_event),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d events still expected",
                  cycle_count, pending_events.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side stalls
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // event beat checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            $error("unexpected event beat: is_press %0b event_code %h last_event %0b",
                   rsp_is_press, rsp_event_code, rsp_last_event);
            failures++;
         end else begin
            want_event = pending_events.pop_front();
            events_checked++;
            if (rsp_is_press !== want_event.is_press) begin
               $error("is_press mismatch: expected %0b actual %0b",
                      want_event.is_press, rsp_is_press);
               failures++;
            end
            if (rsp_event_code !== want_event.code) begin
               $error("event_code mismatch: expected %h actual %h",
                      want_event.code, rsp_event_code);
               failures++;
            end
            if (rsp_last_event !== want_event.last) begin
               $error("last_event mismatch: expected %0b actual %0b",
                      want_event.last, rsp_last_event);
               failures++;
            end
         end
      end
   end

   function automatic void note_event(input logic press, input code_type code);
      key_event_type ev;
      ev.is_press = press;
      ev.code     = code;
      ev.last     = 1'b0;
      pending_events.push_back(ev);
   endfunction

   // diff one report against the held table and queue the resulting events
   function automatic void predict_events(input key_report_type r);
      int            used;
      int            i;
      int            j;
      int            b;
      int            start_size;
      bit            release_all;
      bit            found;
      bit            placed;
      code_type      key [CODE_FIELDS];
      key_event_type ev;
      if (r.count == '0)
         return;
      start_size = pending_events.size();
      used = r.count;
      if (used > CODE_FIELDS)
         used = CODE_FIELDS;
      if (used > REPORT_KEYS)
         used = REPORT_KEYS;
      release_all = 1'b0;
      for (j = 0; j < used; j++) begin
         key[j] = r.codes[j] & ~keypad_mask;
         if (r.codes[j] != caps_code && key[j] == '0)
            release_all = 1'b1;
      end
      for (b = 0; b < MOD_W; b++) begin
         if (last_mods[b] != r.mods[b])
            note_event(r.mods[b], code_type'(mod_base + b));
      end
      last_mods = r.mods;
      if (release_all) begin
         for (i = 0; i < SLOT_COUNT; i++) begin
            if (held_codes[i] != '0) begin
               note_event(1'b0, held_codes[i]);
               held_codes[i] = '0;
            end
         end
      end
      for (i = 0; i < SLOT_COUNT; i++) begin
         if (held_codes[i] != '0) begin
            found = 1'b0;
            for (j = 0; j < used; j++)
               if (key[j] == held_codes[i])
                  found = 1'b1;
            if (!found) begin
               note_event(1'b0, held_codes[i]);
               held_codes[i] = '0;
            end
         end
      end
      for (j = 0; j < used; j++) begin
         found = 1'b0;
         for (i = 0; i < SLOT_COUNT; i++)
            if (held_codes[i] == key[j])
               found = 1'b1;
         if (!found) begin
            placed = 1'b0;
            for (i = 0; i < SLOT_COUNT && !placed; i++) begin
               if (held_codes[i] == '0) begin
                  held_codes[i] = key[j];
                  note_event(1'b1, key[j]);
                  placed = 1'b1;
               end
            end
         end
      end
      if (pending_events.size() > start_size) begin
         ev = pending_events.pop_back();
         ev.last = 1'b1;
         pending_events.push_back(ev);
      end
   endfunction

   function automatic key_report_type mk_report(input logic [MOD_W-1:0] mods,
                                                input logic [COUNT_W-1:0] count,
                                                input code_type c0 = '0,
                                                input code_type c1 = '0,
                                                input code_type c2 = '0,
                                                input code_type c3 = '0,
                                                input code_type c4 = '0,
                                                input code_type c5 = '0,
                                                input code_type c6 = '0,
                                                input code_type c7 = '0);
      key_report_type r;
      r.mods     = mods;
      r.count    = count;
      r.codes[0] = c0;
      r.codes[1] = c1;
      r.codes[2] = c2;
      r.codes[3] = c3;
      r.codes[4] = c4;
      r.codes[5] = c5;
      r.codes[6] = c6;
      r.codes[7] = c7;
      return r;
   endfunction

   function automatic code_type pick_code();
      code_type c;
      case ($urandom_range(0, 39))
         0: c = '0;
         1: c = caps_code;
         2, 3, 4, 5: c = code_type'($urandom);
         default: begin
            c = code_type'($urandom_range(1, 12));
            if ($urandom_range(0, 3) == 0)
               c = c | keypad_mask;
         end
      endcase
      return c;
   endfunction

   // mostly small edits of the previous report, like a real typing sequence
   function automatic key_report_type random_report();
      key_report_type r;
      int             j;
      int             k;
      r = last_report;
      if ($urandom_range(0, 9) < 7 && r.count != '0 && r.count <= CODE_FIELDS) begin
         case ($urandom_range(0, 3))
            0: begin
               if (r.count < CODE_FIELDS) begin
                  r.codes[r.count] = pick_code();
                  r.count = r.count + 1'b1;
               end
            end
            1: begin
               if (r.count > 1) begin
                  k = $urandom_range(0, r.count - 1);
                  r.codes[k] = r.codes[r.count - 1];
                  r.count = r.count - 1'b1;
               end
            end
            2: r.codes[$urandom_range(0, r.count - 1)] = pick_code();
            default: begin
               k = $urandom_range(0, MOD_W - 1);
               r.mods[k] = ~r.mods[k];
            end
         endcase
      end else begin
         r.mods = MOD_W'($urandom);
         case ($urandom_range(0, 11))
            0: r.count = '0;
            1: r.count = COUNT_W'($urandom_range(9, 15));
            default: r.count = COUNT_W'($urandom_range(1, 8));
         endcase
         for (j = 0; j < CODE_FIELDS; j++)
            r.codes[j] = pick_code();
      end
      last_report = r;
      return r;
   endfunction

   task automatic send_report(input key_report_type r);
      if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      predict_events(r);
      req_valid         <= 1'b1;
      req_modifier_bits <= r.mods;
      req_key_count     <= r.count;
      req_code_a        <= r.codes[0];
      req_code_b        <= r.codes[1];
      req_code_c        <= r.codes[2];
      req_code_d        <= r.codes[3];
      req_code_e        <= r.codes[4];
      req_code_f        <= r.codes[5];
      req_code_g        <= r.codes[6];
      req_code_h        <= r.codes[7];
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      reports_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input code_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_KEYPAD_MASK: keypad_mask = data;
         CSR_CAPS_CODE:   caps_code = data;
         CSR_MOD_BASE:    mod_base = data;
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic program_regs(input code_type mask, input code_type caps,
                               input code_type base);
      write_reg(CSR_KEYPAD_MASK, mask);
      write_reg(CSR_CAPS_CODE, caps);
      write_reg(CSR_MOD_BASE, base);
      write_reg(CSR_UNUSED, code_type'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_reports(input int n);
      repeat (n) send_report(random_report());
      wait_idle();
   endtask

   task automatic test_modifiers_and_zero_count();
      send_report(mk_report(8'h00, 4'd0, 16'h0004, 16'h0005));
      send_report(mk_report(8'hFF, 4'd1, 16'h0004));
      // keypad flag and a repeated code in one report
      send_report(mk_report(8'hA5, 4'd3, 16'h0004, 16'h4005, 16'h0005));
      send_report(mk_report(8'h00, 4'd0, 16'h0009));
      send_report(mk_report(8'hA5, 4'd2, 16'h0005, 16'h0006));
      wait_idle();
   endtask

   task automatic test_release_all();
      send_report(mk_report(8'h00, 4'd8, 16'h0011, 16'h0012, 16'h0013, 16'h0014,
                            16'h0015, 16'h0016, 16'h0017, 16'h0018));
      send_report(mk_report(8'h00, 4'd3, 16'h0011, 16'h0000, 16'h0012));
      // keypad flag alone masks to zero
      send_report(mk_report(8'h01, 4'd2, 16'h4000, 16'h0013));
      wait_idle();
   endtask

   task automatic test_count_saturation();
      send_report(mk_report(8'h01, 4'd15, 16'h0021, 16'h0022, 16'h0023, 16'h0024,
                            16'h0025, 16'h0026, 16'h0027, 16'h0028));
      send_report(mk_report(8'h80, 4'd9, 16'h0021, 16'h0022, 16'h0023, 16'h0024,
                            16'h0025, 16'h0026, 16'h0027, 16'hFFFF));
      wait_idle();
   endtask

   task automatic test_caps_lock_and_base_wrap();
      send_report(mk_report(8'h80, 4'd1, 16'h8039));
      wait_idle();
      program_regs(16'h8039, 16'h8039, 16'hFFFC);
      // caps code masks to zero but must not release all
      send_report(mk_report(8'hFF, 4'd3, 16'h8039, 16'h0002, 16'h0004));
      send_report(mk_report(8'hFF, 4'd2, 16'h0001, 16'h0003));
      wait_idle();
      program_regs(16'hFFFF, 16'hFFFF, 16'h0000);
      send_report(mk_report(8'h00, 4'd8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_report(mk_report(8'h01, 4'd1, 16'h1234));
      wait_idle();
      program_regs(16'h0000, 16'h0000, 16'hFFFF);
      send_report(mk_report(8'h03, 4'd2, 16'h0000, 16'hFFFF));
      send_report(mk_report(8'h03, 4'd1, 16'h0000));
      wait_idle();
   endtask

   task automatic test_random_defaults();
      program_regs(KEYPAD_MASK_RESET, CAPS_CODE_RESET, MOD_BASE_RESET);
      gap_odds   = 3;
      stall_odds = 6;
      random_reports(45);
   endtask

   task automatic test_random_no_mask();
      program_regs(16'h0000, 16'h0000, 16'hFFFF);
      gap_odds   = 1;
      stall_odds = 2;
      random_reports(30);
   endtask

   task automatic test_random_full_mask();
      program_regs(16'hFFFF, code_type'($urandom), 16'h0000);
      gap_odds   = 5;
      stall_odds = 10;
      random_reports(15);
   endtask

   task automatic test_random_config();
      program_regs(code_type'($urandom) & 16'hC0F0, code_type'($urandom_range(1, 12)),
                   code_type'($urandom));
      gap_odds   = 4;
      stall_odds = 4;
      random_reports(30);
   endtask

   task automatic test_random_back_to_back();
      program_regs(KEYPAD_MASK_RESET, CAPS_CODE_RESET, MOD_BASE_RESET);
      gap_odds   = 0;
      stall_odds = 0;
      random_reports(30);
   endtask

   initial begin
      gap_odds          = 3;
      stall_odds        = 5;
      failures          = 0;
      cycle_count       = 0;
      reports_sent      = 0;
      events_checked    = 0;
      reg_writes        = 0;
      keypad_mask       = KEYPAD_MASK_RESET;
      caps_code         = CAPS_CODE_RESET;
      mod_base          = MOD_BASE_RESET;
      last_mods         = '0;
      last_report       = '0;
      foreach (held_codes[i])
         held_codes[i] = '0;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_modifier_bits <= '0;
      req_key_count     <= '0;
      req_code_a        <= '0;
      req_code_b        <= '0;
      req_code_c        <= '0;
      req_code_d        <= '0;
      req_code_e        <= '0;
      req_code_f        <= '0;
      req_code_g        <= '0;
      req_code_h        <= '0;
      csr_valid         <= 1'b0;
      csr_index         <= CSR_KEYPAD_MASK;
      csr_wdata         <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_modifiers_and_zero_count();
      test_release_all();
      test_count_saturation();
      test_caps_lock_and_base_wrap();
      test_random_defaults();
      test_random_no_mask();
      test_random_full_mask();
      test_random_config();
      test_random_back_to_back();

      $display("covered %0d reports and %0d register writes over six register settings",
               reports_sent, reg_writes);
      $display("checked %0d events, %0d mismatches", events_checked, failures);
      if (failures == 0 && pending_events.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

FILE: files.f
+incdir+src
src/kedu_pkg.sv
src/kedu_lane.sv
src/kedu_seq.sv
src/keyboard_report_event_diff_unit.sv
sim/tb.sv
